### rtl/smalu_pkg.sv
// Shared types and constants for the eight-bit ALU with Z/N/H/C flags.
// Holds the operation codes, flag bit positions and request/response structs.
// No dependencies.
`default_nettype none

package smalu_pkg;

  // Operation codes carried in req_type
  typedef enum logic [4:0] {
    OP_INC    = 5'd0,
    OP_DEC    = 5'd1,
    OP_ADD    = 5'd2,
    OP_ADC    = 5'd3,
    OP_ADD16  = 5'd4,
    OP_SUB    = 5'd5,
    OP_SBC    = 5'd6,
    OP_AND    = 5'd7,
    OP_OR     = 5'd8,
    OP_XOR    = 5'd9,
    OP_SWAP   = 5'd10,
    OP_DAA    = 5'd11,
    OP_CPL    = 5'd12,
    OP_CCF    = 5'd13,
    OP_SCF    = 5'd14,
    OP_RLC    = 5'd15,
    OP_RLCA   = 5'd16,
    OP_RL     = 5'd17,
    OP_RLA    = 5'd18,
    OP_RRC    = 5'd19,
    OP_RRCA   = 5'd20,
    OP_RR     = 5'd21,
    OP_RRA    = 5'd22,
    OP_SLA    = 5'd23,
    OP_SRA    = 5'd24,
    OP_SRL    = 5'd25,
    OP_BIT    = 5'd26,
    OP_SET    = 5'd27,
    OP_RES    = 5'd28,
    OP_ADD_SP = 5'd29
  } alu_op_t;

  // Flag bit positions within the 4-bit flag field
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants
  localparam logic [7:0] DAA_LIMIT   = 8'h99;
  localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
  localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
  localparam logic [3:0] DAA_LO_MAX  = 4'h9;

  // One operation as the core sees it
  typedef struct packed {
    logic [4:0]  req_type;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags_in;
  } alu_req_t;

  // One result
  typedef struct packed {
    logic [15:0] result_value;
    logic [3:0]  flags_out;
  } alu_rsp_t;

endpackage

`default_nettype wire

### rtl/smalu_core.sv
// Combinational datapath of the ALU: adders, shifter, logic unit and flag update.
// Depends on smalu_pkg for operation codes, flag positions and structs.
`default_nettype none

module smalu_core (
  input  wire smalu_pkg::alu_req_t req,
  output smalu_pkg::alu_rsp_t      rsp
);
  import smalu_pkg::*;

  alu_op_t     op;
  logic [7:0]  a;
  logic [7:0]  b;
  logic        cin;
  logic        cin_eff;
  logic [8:0]  sum9;
  logic [4:0]  half_sum;
  logic [8:0]  diff9;
  logic [4:0]  half_diff;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_low;
  logic [7:0]  daa_hi;
  logic [7:0]  daa_r;
  logic        daa_c;
  logic [7:0]  bit_mask;
  logic [15:0] r;
  logic [3:0]  f;
  logic        setz;

  assign op       = alu_op_t'(req.req_type);
  assign a        = req.operand_a[7:0];
  assign b        = req.operand_b[7:0];
  assign cin      = req.flags_in[FLAG_C];
  assign bit_mask = 8'd1 << req.bit_index;

  // The adders take the carry-in only for the with-carry forms
  assign cin_eff = ((op == OP_ADC) || (op == OP_SBC)) ? cin : 1'b0;

  // Byte add and subtract with nibble carries
  assign sum9      = {1'b0, a} + {1'b0, b} + {8'd0, cin_eff};
  assign half_sum  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin_eff};
  assign diff9     = {1'b0, a} - {1'b0, b} - {8'd0, cin_eff};
  assign half_diff = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin_eff};

  // 16-bit add with carries out of bit 11 and bit 15
  assign sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
  assign sum13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};

  // Stack pointer plus signed byte; flags come from the low byte
  assign sp_sum  = req.operand_a + {{8{b[7]}}, b};
  assign sp_half = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};
  assign sp_low  = {1'b0, req.operand_a[7:0]} + {1'b0, b};

  // Decimal adjust after add or subtract
  always_comb begin
    daa_c  = req.flags_in[FLAG_C];
    daa_hi = a;
    daa_r  = a;
    if (!req.flags_in[FLAG_N]) begin
      if (req.flags_in[FLAG_C] || (a > DAA_LIMIT)) begin
        daa_hi = a + DAA_HI_ADJ;
        daa_c  = 1'b1;
      end
      daa_r = daa_hi;
      if (req.flags_in[FLAG_H] || (daa_hi[3:0] > DAA_LO_MAX)) begin
        daa_r = daa_hi + DAA_LO_ADJ;
      end
    end else begin
      if (req.flags_in[FLAG_C]) begin
        daa_hi = a - DAA_HI_ADJ;
      end
      daa_r = daa_hi;
      if (req.flags_in[FLAG_H]) begin
        daa_r = daa_hi - DAA_LO_ADJ;
      end
    end
  end

  // Select result and update flags
  always_comb begin
    r    = 16'd0;
    f    = req.flags_in;
    setz = 1'b1;
    case (op)
      OP_INC: begin
        r[7:0]    = a + 8'd1;
        f[FLAG_H] = (r[3:0] == 4'h0);
        f[FLAG_N] = 1'b0;
      end
      OP_DEC: begin
        r[7:0]    = a - 8'd1;
        f[FLAG_H] = (r[3:0] == 4'hF);
        f[FLAG_N] = 1'b1;
      end
      OP_ADD, OP_ADC: begin
        r[7:0]    = sum9[7:0];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = half_sum[4];
        f[FLAG_C] = sum9[8];
      end
      OP_ADD16: begin
        r         = sum17[15:0];
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = sum13[12];
        f[FLAG_C] = sum17[16];
        setz      = 1'b0;
      end
      OP_SUB, OP_SBC: begin
        r[7:0]    = diff9[7:0];
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = half_diff[4];
        f[FLAG_C] = diff9[8];
      end
      OP_AND: begin
        r[7:0]    = a & b;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b1;
        f[FLAG_C] = 1'b0;
      end
      OP_OR, OP_XOR, OP_SWAP: begin
        case (op)
          OP_OR:   r[7:0] = a | b;
          OP_XOR:  r[7:0] = a ^ b;
          default: r[7:0] = {a[3:0], a[7:4]};
        endcase
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b0;
        f[FLAG_C] = 1'b0;
      end
      OP_DAA: begin
        r[7:0]    = daa_r;
        f[FLAG_C] = daa_c;
        f[FLAG_H] = 1'b0;
      end
      OP_CPL: begin
        r[7:0]    = ~a;
        f[FLAG_N] = 1'b1;
        f[FLAG_H] = 1'b1;
        setz      = 1'b0;
      end
      OP_CCF, OP_SCF: begin
        r[7:0]    = a;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b0;
        f[FLAG_C] = (op == OP_SCF) ? 1'b1 : ~req.flags_in[FLAG_C];
        setz      = 1'b0;
      end
      OP_RLC, OP_RLCA, OP_RL, OP_RLA, OP_SLA: begin
        case (op)
          OP_RLC, OP_RLCA: r[7:0] = {a[6:0], a[7]};
          OP_RL, OP_RLA:   r[7:0] = {a[6:0], cin};
          default:         r[7:0] = {a[6:0], 1'b0};
        endcase
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b0;
        f[FLAG_C] = a[7];
      end
      OP_RRC, OP_RRCA, OP_RR, OP_RRA, OP_SRA, OP_SRL: begin
        case (op)
          OP_RRC, OP_RRCA: r[7:0] = {a[0], a[7:1]};
          OP_RR, OP_RRA:   r[7:0] = {cin, a[7:1]};
          OP_SRA:          r[7:0] = {a[7], a[7:1]};
          default:         r[7:0] = {1'b0, a[7:1]};
        endcase
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b0;
        f[FLAG_C] = a[0];
      end
      OP_BIT: begin
        r[7:0]    = a;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = 1'b1;
        f[FLAG_Z] = ((a & bit_mask) == 8'd0);
        setz      = 1'b0;
      end
      OP_SET: begin
        r[7:0] = a | bit_mask;
        setz   = 1'b0;
      end
      OP_RES: begin
        r[7:0] = a & ~bit_mask;
        setz   = 1'b0;
      end
      OP_ADD_SP: begin
        r         = sp_sum;
        f[FLAG_Z] = 1'b0;
        f[FLAG_N] = 1'b0;
        f[FLAG_H] = sp_half[4];
        f[FLAG_C] = sp_low[8];
        setz      = 1'b0;
      end
      default: begin
        r    = 16'd0;
        setz = 1'b0;
      end
    endcase

    if (setz) begin
      f[FLAG_Z] = (r == 16'd0);
    end
    // Accumulator rotates always clear Z
    if ((op == OP_RLCA) || (op == OP_RLA) || (op == OP_RRCA) || (op == OP_RRA)) begin
      f[FLAG_Z] = 1'b0;
    end
  end

  assign rsp.result_value = r;
  assign rsp.flags_out    = f;

endmodule

`default_nettype wire

### rtl/cpu_alu_with_flags.sv
// Path: an accepted input item passes through the input register, then the result register, to out_tvalid.
// Throughput: one item per cycle; the input and result registers form a two-deep pipeline
// that keeps accepting while a result waits, stalling only when both hold an item
// and out_tready is low.
// Reset: rst_n synchronous, active low; clears both valid flags, payload is not reset.
// Top level of the ALU; depends on smalu_pkg and smalu_core.
`default_nettype none

module cpu_alu_with_flags (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [4:0] req_type, [20:5] operand_a, [36:21] operand_b, [39:37] bit_index,
  // [43:40] flags_in, [47:44] unused
  input  wire logic [47:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] result_value, [19:16] flags_out, [23:20] zero
  output logic [23:0]      out_tdata
);
  import smalu_pkg::*;

  logic     req_valid_r;
  alu_req_t req_r;
  alu_req_t req_nxt;
  logic     out_valid_r;
  alu_rsp_t rsp_r;
  alu_rsp_t rsp_nxt;
  logic     out_free;

  // Unpack the input item
  assign req_nxt.req_type  = in_tdata[4:0];
  assign req_nxt.operand_a = in_tdata[20:5];
  assign req_nxt.operand_b = in_tdata[36:21];
  assign req_nxt.bit_index = in_tdata[39:37];
  assign req_nxt.flags_in  = in_tdata[43:40];

  // Advance when the next stage is empty or draining
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !req_valid_r || out_free;

  smalu_core u_core (
    .req (req_r),
    .rsp (rsp_nxt)
  );

  // Hold stage valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        req_valid_r <= in_tvalid;
      end
      if (out_free) begin
        out_valid_r <= req_valid_r;
      end
    end
  end

  // Load payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      req_r <= req_nxt;
    end
    if (out_free && req_valid_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, rsp_r.flags_out, rsp_r.result_value};

endmodule

`default_nettype wire
